### src/cpl_pkg.sv
// Shared widths, payload types and status codes for the closest-point block.
// No dependencies; imported by cpl_front, cpl_fifo, cpl_back and closest_point_of_two_lines.
package cpl_pkg;

  localparam int CW     = 32;           // coordinate width
  localparam int FB     = 16;           // fraction bits
  localparam int TW     = 32;           // threshold register width
  localparam int SW     = CW + 1;       // p0 - p1, p0 + p1
  localparam int DW     = 2 * SW + 1;   // dot products a..e
  localparam int PW     = 2 * DW;       // products of dots
  localparam int KW     = PW + 1;       // det, sn, tn and the selected K, S, T
  localparam int NW     = KW + SW + 2;  // numerator and divider datapath
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [2:0][CW-1:0] cvec_t;
  typedef logic [2:0][SW-1:0] evec_t;

  typedef struct packed {
    cvec_t v0;
    cvec_t v1;
    evec_t w;
    evec_t sum;
  } item_t;

  typedef enum logic [1:0] {
    ST_SKEW  = 2'd0,
    ST_PAR   = 2'd1,
    ST_DEGEN = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

endpackage

### src/cpl_front.sv
// Input stage: registers each line pair and forms p0 - p1 and p0 + p1.
// Depends on cpl_pkg.
module cpl_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [12*cpl_pkg::CW-1:0] in_data,
  output logic                     item_valid,
  input  logic                     item_ready,
  output cpl_pkg::item_t           item
);
  import cpl_pkg::*;

  logic  fv_r;
  item_t item_r;
  item_t item_nxt;
  cvec_t p0;
  cvec_t p1;

  assign p0 = in_data[0*CW +: 3*CW];
  assign p1 = in_data[6*CW +: 3*CW];

  always_comb begin
    item_nxt.v0 = in_data[3*CW +: 3*CW];
    item_nxt.v1 = in_data[9*CW +: 3*CW];
    for (int i = 0; i < 3; i++) begin
      item_nxt.w[i]   = SW'($signed(p0[i])) - SW'($signed(p1[i]));
      item_nxt.sum[i] = SW'($signed(p0[i])) + SW'($signed(p1[i]));
    end
  end

  assign in_ready   = !fv_r || item_ready;
  assign item_valid = fv_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

### src/cpl_fifo.sv
// Short queue between the input stage and the arithmetic pipeline.
// Depends on cpl_pkg.
module cpl_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cpl_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cpl_pkg::item_t rd_item
);
  import cpl_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           push;
  logic           pop;

  assign wr_ready = cnt_r != (QAW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

### src/cpl_mul.sv
// Pipelined signed multiplier: one 16-bit digit of a per stage times all of b.
// The stages advance on en. Depends on nothing.
module cpl_mul #(
  parameter int AW = 67,
  parameter int BW = 67
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  localparam int ND  = (AW + 15) / 16;
  localparam int APW = ND * 16;
  localparam int RW  = AW + BW;

  logic        [APW-1:0] a_r   [ND];
  logic signed [BW-1:0]  b_r   [ND];
  logic signed [RW-1:0]  acc_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic        [APW-1:0] a_in;
    logic signed [BW-1:0]  b_in;
    logic signed [RW-1:0]  acc_in;
    logic signed [16:0]    dig;
    logic signed [BW+16:0] pp;
    logic signed [RW-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign a_in   = APW'(a);
      assign b_in   = b;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    // top digit carries the sign of a
    if (k == ND - 1) begin : g_top
      assign dig = {a_in[16*k+15], a_in[16*k +: 16]};
    end else begin : g_low
      assign dig = {1'b0, a_in[16*k +: 16]};
    end

    assign pp      = b_in * dig;
    assign acc_nxt = acc_in + ({{(RW-BW-17){pp[BW+16]}}, pp} <<< (16 * k));

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign p = acc_r[ND-1];

endmodule

### src/cpl_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// The stages advance on en. Depends on nothing.
module cpl_div #(
  parameter int NW = 170,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] q,
  output logic          ovf
);
  logic [NW-1:0] rem_r [QW+1];
  logic [NW-1:0] dv_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  // quotient does not fit in QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      dv_r[0]  <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num >= (den << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_bit
    logic [NW-1:0] sh;
    logic          ge;
    logic [QW-1:0] q_nxt;

    assign sh = dv_r[j-1] << (QW - j);
    assign ge = rem_r[j-1] >= sh;

    always_comb begin
      q_nxt = q_r[j-1];
      q_nxt[QW-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - sh : rem_r[j-1];
        dv_r[j]  <= dv_r[j-1];
        q_r[j]   <= q_nxt;
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

### src/cpl_back.sv
// Arithmetic pipeline: dots, determinant, branch select, numerators, division.
// Depends on cpl_pkg, cpl_mul and cpl_div.
module cpl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cpl_pkg::TW-1:0]      thr,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpl_pkg::item_t              in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cpl_pkg::cvec_t              out_mid,
  output logic [1:0]                  out_status
);
  import cpl_pkg::*;

  localparam int M1 = (DW + 15) / 16;
  localparam int M2 = (KW + 15) / 16;
  localparam int DL = CW + 1;
  localparam int LT = 2 + M1 + 2 + M2 + 1 + DL + 1;

  typedef struct packed {
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] d;
    item_t                it;
  } cside_t;

  typedef struct packed {
    logic signed [KW-1:0] k;
    status_t              st;
  } fside_t;

  typedef struct packed {
    logic [2:0] neg;
    status_t    st;
  } dside_t;

  logic [LT-1:0] vld_r;
  logic          en;

  assign en        = !vld_r[LT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LT-2:0], in_valid};
    end
  end

  // stage A: elementwise products
  logic signed [2*SW-1:0] pa_r [3];
  logic signed [2*SW-1:0] pb_r [3];
  logic signed [2*SW-1:0] pc_r [3];
  logic signed [2*SW-1:0] pd_r [3];
  logic signed [2*SW-1:0] pe_r [3];
  item_t                  itA_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= $signed(in_item.v0[i]) * $signed(in_item.v0[i]);
        pb_r[i] <= $signed(in_item.v0[i]) * $signed(in_item.v1[i]);
        pc_r[i] <= $signed(in_item.v1[i]) * $signed(in_item.v1[i]);
        pd_r[i] <= $signed(in_item.v0[i]) * $signed(in_item.w[i]);
        pe_r[i] <= $signed(in_item.v1[i]) * $signed(in_item.w[i]);
      end
      itA_r <= in_item;
    end
  end

  // stage B: dot products
  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;
  item_t                itB_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= DW'(pa_r[0]) + DW'(pa_r[1]) + DW'(pa_r[2]);
      b_r   <= DW'(pb_r[0]) + DW'(pb_r[1]) + DW'(pb_r[2]);
      c_r   <= DW'(pc_r[0]) + DW'(pc_r[1]) + DW'(pc_r[2]);
      d_r   <= DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
      e_r   <= DW'(pe_r[0]) + DW'(pe_r[1]) + DW'(pe_r[2]);
      itB_r <= itA_r;
    end
  end

  // stage C: products of dots
  logic signed [PW-1:0] ac, bb, be, cd, ae, bd;
  cside_t               cs_r [M1];

  cpl_mul #(.AW(DW), .BW(DW)) u_ac (.clk, .en, .a(a_r), .b(c_r), .p(ac));
  cpl_mul #(.AW(DW), .BW(DW)) u_bb (.clk, .en, .a(b_r), .b(b_r), .p(bb));
  cpl_mul #(.AW(DW), .BW(DW)) u_be (.clk, .en, .a(b_r), .b(e_r), .p(be));
  cpl_mul #(.AW(DW), .BW(DW)) u_cd (.clk, .en, .a(c_r), .b(d_r), .p(cd));
  cpl_mul #(.AW(DW), .BW(DW)) u_ae (.clk, .en, .a(a_r), .b(e_r), .p(ae));
  cpl_mul #(.AW(DW), .BW(DW)) u_bd (.clk, .en, .a(b_r), .b(d_r), .p(bd));

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r[0] <= '{b: b_r, d: d_r, it: itB_r};
      for (int k = 1; k < M1; k++) cs_r[k] <= cs_r[k-1];
    end
  end

  // stage D: determinant and line-parameter numerators
  logic signed [KW-1:0] det_r, sn_r, tn_r;
  cside_t               csD_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= KW'(ac) - KW'(bb);
      sn_r  <= KW'(be) - KW'(cd);
      tn_r  <= KW'(ae) - KW'(bd);
      csD_r <= cs_r[M1-1];
    end
  end

  // stage E: parallel test; numerator is K*sum + S*v0 + T*v1 over 2K
  logic        [KW-1:0] absdet;
  logic                 par;
  logic signed [KW-1:0] k_nxt, s_nxt, t_nxt;
  status_t              st_nxt;
  logic signed [KW-1:0] k_r, s_r, t_r;
  status_t              stE_r;
  item_t                itE_r;

  always_comb begin
    absdet = det_r[KW-1] ? -det_r : det_r;
    par    = (det_r == '0) || (absdet < (KW'(thr) << (3 * FB)));
    if (!par) begin
      k_nxt  = det_r;
      s_nxt  = sn_r;
      t_nxt  = tn_r;
      st_nxt = ST_SKEW;
    end else if (csD_r.b == '0) begin
      k_nxt  = KW'(1);
      s_nxt  = '0;
      t_nxt  = '0;
      st_nxt = ST_DEGEN;
    end else begin
      k_nxt  = KW'(csD_r.b);
      s_nxt  = '0;
      t_nxt  = KW'(csD_r.d);
      st_nxt = ST_PAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r   <= k_nxt;
      s_r   <= s_nxt;
      t_r   <= t_nxt;
      stE_r <= st_nxt;
      itE_r <= csD_r.it;
    end
  end

  // stage F: numerator terms
  logic signed [KW+SW-1:0] mk [3];
  logic signed [KW+SW-1:0] ms [3];
  logic signed [KW+SW-1:0] mt [3];
  fside_t                  fs_r [M2];

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpl_mul #(.AW(KW), .BW(SW)) u_mk (
      .clk, .en, .a(k_r), .b($signed(itE_r.sum[i])), .p(mk[i]));
    cpl_mul #(.AW(KW), .BW(SW)) u_ms (
      .clk, .en, .a(s_r), .b($signed({itE_r.v0[i][CW-1], itE_r.v0[i]})), .p(ms[i]));
    cpl_mul #(.AW(KW), .BW(SW)) u_mt (
      .clk, .en, .a(t_r), .b($signed({itE_r.v1[i][CW-1], itE_r.v1[i]})), .p(mt[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs_r[0] <= '{k: k_r, st: stE_r};
      for (int k = 1; k < M2; k++) fs_r[k] <= fs_r[k-1];
    end
  end

  // stage G: magnitudes; round(|n|/|2K|) = floor((|n| + |K|) / 2|K|)
  logic signed [NW-1:0] num [3];
  logic        [NW-1:0] nabs [3];
  logic        [NW-1:0] kabs;
  logic        [NW-1:0] nq_r [3];
  logic        [NW-1:0] dd_r;
  dside_t               dsG_r;
  logic         [2:0]   neg_nxt;

  always_comb begin
    kabs = fs_r[M2-1].k[KW-1] ? NW'(-fs_r[M2-1].k) : NW'(fs_r[M2-1].k);
    for (int i = 0; i < 3; i++) begin
      num[i]     = NW'(mk[i]) + NW'(ms[i]) + NW'(mt[i]);
      nabs[i]    = num[i][NW-1] ? -num[i] : num[i];
      neg_nxt[i] = num[i][NW-1] ^ fs_r[M2-1].k[KW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) nq_r[i] <= nabs[i] + kabs;
      dd_r  <= kabs << 1;
      dsG_r <= '{neg: neg_nxt, st: fs_r[M2-1].st};
    end
  end

  // division
  logic [CW-1:0] q   [3];
  logic          ovf [3];
  dside_t        ds_r [DL];

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpl_div #(.NW(NW), .QW(CW)) u_div (
      .clk, .en, .num(nq_r[i]), .den(dd_r), .q(q[i]), .ovf(ovf[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= dsG_r;
      for (int k = 1; k < DL; k++) ds_r[k] <= ds_r[k-1];
    end
  end

  // stage H: sign, saturation, output register
  cvec_t      mid_nxt;
  logic [2:0] sat;
  cvec_t      mid_r;
  status_t    st_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!ds_r[DL-1].neg[i]) begin
        sat[i]     = ovf[i] || q[i][CW-1];
        mid_nxt[i] = sat[i] ? {1'b0, {(CW-1){1'b1}}} : q[i];
      end else begin
        sat[i]     = ovf[i] || (q[i][CW-1] && (q[i][CW-2:0] != '0));
        mid_nxt[i] = sat[i] ? {1'b1, {(CW-1){1'b0}}} : -q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= mid_nxt;
      st_r  <= (sat != '0) ? ST_SAT : ds_r[DL-1].st;
    end
  end

  assign out_mid    = mid_r;
  assign out_status = st_r;

endmodule

### src/closest_point_of_two_lines.sv
// Closest point of two 3D lines: midpoint of the shortest joining segment.
// Instantiates cpl_front, cpl_fifo and cpl_back; depends on cpl_pkg.
//
// Input channel in_*: one transfer carries both lines (points and directions,
// signed Q16.16). Output channel out_*: one transfer per input transfer, in
// order, with the midpoint in tdata and the status code in tuser.
// Configuration: cfg_wr_en writes cfg_wr_data into the parallel threshold
// (units of 2^-16 on |det|); write it only while the block is empty.
// Throughput: one line pair per cycle while out_tready is high. Pipeline depth
// is set by the digit-serial multipliers (5 and 9 stages) and the
// 33-stage quotient pipeline of the divider.
// Reset clears all valid flags and the queue and sets the threshold to 1.
// When out_tready is low the arithmetic pipeline holds; the four-entry queue
// and the input register keep accepting until they fill, then in_tready drops.
module closest_point_of_two_lines (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // p0_x, p0_y, p0_z, v0_x, v0_y, v0_z, p1_x, p1_y, p1_z, v1_x, v1_y, v1_z
  input  logic [12*cpl_pkg::CW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // mid_x, mid_y, mid_z
  output logic [3*cpl_pkg::CW-1:0]   out_tdata,
  // status
  output logic [1:0]                 out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [cpl_pkg::TW-1:0]     cfg_wr_data
);
  import cpl_pkg::*;

  logic [TW-1:0] thr_r;
  logic          fq_valid, fq_ready;
  item_t         fq_item;
  logic          qb_valid, qb_ready;
  item_t         qb_item;
  cvec_t         mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= TW'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  cpl_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .item_valid(fq_valid), .item_ready(fq_ready), .item(fq_item)
  );

  cpl_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
  );

  cpl_back u_back (
    .clk, .rst_n, .thr(thr_r),
    .in_valid(qb_valid), .in_ready(qb_ready), .in_item(qb_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_mid(mid), .out_status(out_tuser)
  );

  assign out_tdata = mid;

endmodule
